// ===== design/scsa_pkg.sv =====
// Shared types and constants for the size class slot allocator.
package scsa_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] req_size;
    logic [31:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] slot_addr;
    logic [5:0]  size_class;
    logic [2:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLS,
    S_FIX,
    S_RD1,
    S_RD2,
    S_ARN,
    S_DIV,
    S_PAD,
    S_FIN,
    S_DONE
  } state_t;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [2:0] ST_FROM_STACK = 3'd0;
  localparam logic [2:0] ST_CARVED     = 3'd1;
  localparam logic [2:0] ST_OVERSIZE   = 3'd2;
  localparam logic [2:0] ST_IGNORED    = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd4;
  localparam logic [2:0] ST_STACK_FULL = 3'd5;

  localparam logic [1:0] REG_ARENA_BASE  = 2'd0;
  localparam logic [1:0] REG_ARENA_LIMIT = 2'd1;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd2;

  localparam logic [20:0] BLOCK_BYTES_RST = 21'd4096;
  localparam int          HDR_BYTES       = 8;

endpackage

// ===== design/size_class_slot_allocator_unit.sv =====
// Top level of the size class slot allocator: control, class table and free stacks.
// Path: special cases go from S_IDLE straight to S_DONE; stack pop/push and carve pass S_CLS,
//   S_FIX, S_RD1 (S_RD2 for a pop); new block refill adds S_ARN, S_DIV, S_PAD and S_FIN.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: synchronous active low; class entries read as zero until first written,
//   free stack memory holds no reset value and is only read where written.
module size_class_slot_allocator_unit #(
  parameter int NUM_CLASSES     = 64,
  parameter int BASE_SLOT_BYTES = 8,
  parameter int FREE_DEPTH      = 256,
  parameter int ADDR_BITS       = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scsa_pkg::req_t      in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output scsa_pkg::rsp_t      out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import scsa_pkg::*;

  localparam int AW     = ADDR_BITS;
  localparam int CLW    = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
  localparam int MAXSZ  = NUM_CLASSES * BASE_SLOT_BYTES;
  localparam int SW     = $clog2(MAXSZ + 1);
  localparam int XW     = $clog2(MAXSZ);
  localparam int SH     = XW + 8;
  localparam longint unsigned RECIP = (64'd1 << SH) / BASE_SLOT_BYTES;
  localparam int MW     = SH + 1;
  localparam int CW     = $clog2(FREE_DEPTH + 1);
  localparam int SDEPTH = NUM_CLASSES * FREE_DEPTH;
  localparam int SAW    = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
  localparam int CTW    = CW + 2 * AW;

  state_t state_r, state_nxt;

  logic [31:0] arena_base_r, arena_limit_r;
  logic [20:0] block_bytes_r;
  logic [AW-1:0] arena_next_r, arena_next_nxt;

  logic            type_r, type_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [XW-1:0]   q0_r, q0_nxt;
  logic [CLW-1:0]  cls_r, cls_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic            vld_rd_r, vld_rd_nxt;
  logic [AW-1:0]   end_r, end_nxt;
  logic [AW-1:0]   body_r, body_nxt;
  logic [AW-1:0]   first_r, first_nxt;
  logic [AW-1:0]   res_addr_r, res_addr_nxt;
  logic [CLW-1:0]  res_cls_r, res_cls_nxt;
  logic [2:0]      res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_word_r, out_word_nxt;
  logic [NUM_CLASSES-1:0] cls_vld_r, cls_vld_nxt;

  logic            ct_we, ct_re;
  logic [CLW-1:0]  ct_waddr, ct_raddr;
  logic [CTW-1:0]  ct_wdata, ct_rdata, ct_q;
  logic            st_we, st_re;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [AW-1:0]   st_wdata, st_rdata;

  logic            div_start, div_done;
  logic [SW-1:0]   div_rem;

  logic [CW-1:0]   cnt_q;
  logic [AW-1:0]   ns_q, be_q;
  logic [XW+MW-1:0] prod;
  logic [XW+8:0]   qb;
  logic [XW+8:0]   rfix;
  logic [XW-1:0]   q_fix;
  logic [AW-1:0]   start_a;
  logic [AW:0]     sum_end, sum_body, bb_ext;
  logic [SW-1:0]   pad;
  logic [AW:0]     span;
  logic [AW-1:0]   slot_a;
  logic            cfg_wr;

  function automatic logic [SAW-1:0] stk_idx(input logic [CLW-1:0] c, input logic [CW-1:0] n);
    stk_idx = SAW'(SAW'(c) * SAW'(FREE_DEPTH) + SAW'(n));
  endfunction

  scsa_ram #(.WIDTH(CTW), .DEPTH(NUM_CLASSES)) u_class_ram (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
    .re(ct_re), .raddr(ct_raddr), .rdata(ct_rdata)
  );

  scsa_ram #(.WIDTH(AW), .DEPTH(SDEPTH)) u_stack_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  scsa_rem_div #(.NW(AW), .DW(SW)) u_rem_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_body[AW-1:0]), .den(slot_r),
    .done(div_done), .rem(div_rem)
  );

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_ARENA_BASE:  prdata = arena_base_r;
      REG_ARENA_LIMIT: prdata = arena_limit_r;
      REG_BLOCK_BYTES: prdata = {11'd0, block_bytes_r};
      default:         prdata = '0;
    endcase
  end

  assign ct_q   = vld_rd_r ? ct_rdata : '0;
  assign cnt_q  = ct_q[CTW-1 -: CW];
  assign ns_q   = ct_q[2*AW-1 -: AW];
  assign be_q   = ct_q[AW-1:0];
  assign slot_a = AW'(slot_r);

  always_comb begin
    state_nxt      = state_r;
    arena_next_nxt = arena_next_r;
    type_nxt       = type_r;
    addr_nxt       = addr_r;
    x_nxt          = x_r;
    q0_nxt         = q0_r;
    cls_nxt        = cls_r;
    slot_nxt       = slot_r;
    vld_rd_nxt     = vld_rd_r;
    end_nxt        = end_r;
    body_nxt       = body_r;
    first_nxt      = first_r;
    res_addr_nxt   = res_addr_r;
    res_cls_nxt    = res_cls_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    cls_vld_nxt    = cls_vld_r;
    in_ready       = 1'b0;
    ct_we          = 1'b0;
    ct_re          = 1'b0;
    ct_waddr       = cls_r;
    ct_raddr       = cls_r;
    ct_wdata       = ct_q;
    st_we          = 1'b0;
    st_re          = 1'b0;
    st_waddr       = stk_idx(cls_r, cnt_q);
    st_raddr       = stk_idx(cls_r, cnt_q - 1'b1);
    st_wdata       = addr_r;
    div_start      = 1'b0;

    prod     = (XW+MW)'(x_r) * (XW+MW)'(RECIP);
    qb       = (XW+9)'(q0_r) * (XW+9)'(BASE_SLOT_BYTES);
    rfix     = (XW+9)'(x_r) - qb;
    q_fix    = (rfix >= (XW+9)'(BASE_SLOT_BYTES)) ? q0_r + 1'b1 : q0_r;
    start_a  = (arena_next_r == '0) ? AW'(arena_base_r) : arena_next_r;
    bb_ext   = (AW+1)'(block_bytes_r);
    sum_end  = {1'b0, start_a} + bb_ext;
    sum_body = {1'b0, start_a} + (AW+1)'(HDR_BYTES);
    pad      = slot_r - div_rem;
    span     = {1'b0, end_r} - {1'b0, body_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          type_nxt    = in_word.req_type;
          addr_nxt    = AW'(in_word.free_addr);
          x_nxt       = XW'(in_word.req_size - 32'd1);
          res_addr_nxt = '0;
          res_cls_nxt  = '0;
          if (in_word.req_size == 32'd0 ||
              (in_word.req_type == REQ_FREE && AW'(in_word.free_addr) == '0)) begin
            res_st_nxt = ST_IGNORED;
            state_nxt  = S_DONE;
          end else if (in_word.req_size > 32'(MAXSZ)) begin
            res_st_nxt = ST_OVERSIZE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CLS;
          end
        end
      end
      S_CLS: begin
        q0_nxt    = XW'(prod >> SH);
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cls_nxt    = CLW'(q_fix);
        slot_nxt   = SW'((SW+1)'(CLW'(q_fix)) * (SW+1)'(BASE_SLOT_BYTES)
                     + (SW+1)'(BASE_SLOT_BYTES));
        ct_re      = 1'b1;
        ct_raddr   = CLW'(q_fix);
        vld_rd_nxt = cls_vld_r[CLW'(q_fix)];
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        res_cls_nxt = cls_r;
        if (type_r == REQ_FREE) begin
          if (cnt_q >= CW'(FREE_DEPTH)) begin
            res_addr_nxt = '0;
            res_st_nxt   = ST_STACK_FULL;
          end else begin
            st_we        = 1'b1;
            ct_we        = 1'b1;
            ct_wdata     = {cnt_q + 1'b1, ns_q, be_q};
            res_addr_nxt = addr_r;
            res_st_nxt   = ST_FROM_STACK;
          end
          state_nxt = S_DONE;
        end else if (cnt_q != '0) begin
          st_re     = 1'b1;
          ct_we     = 1'b1;
          ct_wdata  = {cnt_q - 1'b1, ns_q, be_q};
          state_nxt = S_RD2;
        end else if (ns_q == '0 || ns_q > be_q || (be_q - ns_q) < slot_a) begin
          state_nxt = S_ARN;
        end else begin
          ct_we        = 1'b1;
          ct_wdata     = {cnt_q, ns_q + slot_a, be_q};
          res_addr_nxt = ns_q;
          res_st_nxt   = ST_CARVED;
          state_nxt    = S_DONE;
        end
      end
      S_RD2: begin
        res_addr_nxt = st_rdata;
        res_st_nxt   = ST_FROM_STACK;
        state_nxt    = S_DONE;
      end
      S_ARN: begin
        if (sum_end[AW] || sum_end > (AW+1)'(arena_limit_r[AW > 32 ? 31 : AW-1:0]) ||
            block_bytes_r < 21'(HDR_BYTES) || sum_body[AW]) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_EXHAUSTED;
          state_nxt    = S_DONE;
        end else begin
          end_nxt   = sum_end[AW-1:0];
          body_nxt  = sum_body[AW-1:0];
          state_nxt = S_DIV;
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (div_rem == '0) begin
          first_nxt = body_r;
          state_nxt = S_FIN;
        end else if ((AW+1)'(pad) > span) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_EXHAUSTED;
          state_nxt    = S_DONE;
        end else begin
          first_nxt = body_r + AW'(pad);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if ((end_r - first_r) < slot_a) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_EXHAUSTED;
        end else begin
          arena_next_nxt = end_r;
          ct_we          = 1'b1;
          ct_wdata       = {CW'(0), first_r + slot_a, end_r};
          res_addr_nxt   = first_r;
          res_st_nxt     = ST_CARVED;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.slot_addr  = 32'(res_addr_r);
          out_word_nxt.size_class = 6'(res_cls_r);
          out_word_nxt.status     = res_st_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ct_we) begin
      cls_vld_nxt[ct_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      arena_base_r  <= '0;
      arena_limit_r <= '0;
      block_bytes_r <= BLOCK_BYTES_RST;
      arena_next_r  <= '0;
      out_valid_r   <= 1'b0;
      cls_vld_r     <= '0;
      vld_rd_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      arena_next_r <= arena_next_nxt;
      out_valid_r  <= out_valid_nxt;
      cls_vld_r    <= cls_vld_nxt;
      vld_rd_r     <= vld_rd_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ARENA_BASE:  arena_base_r  <= pwdata;
          REG_ARENA_LIMIT: arena_limit_r <= pwdata;
          REG_BLOCK_BYTES: block_bytes_r <= pwdata[20:0];
          default: begin
          end
        endcase
      end
    end
    type_r     <= type_nxt;
    addr_r     <= addr_nxt;
    x_r        <= x_nxt;
    q0_r       <= q0_nxt;
    cls_r      <= cls_nxt;
    slot_r     <= slot_nxt;
    end_r      <= end_nxt;
    body_r     <= body_nxt;
    first_r    <= first_nxt;
    res_addr_r <= res_addr_nxt;
    res_cls_r  <= res_cls_nxt;
    res_st_r   <= res_st_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_fix_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> (state_r == S_RD1))
    else $error("class table read not followed by use");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");

  a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
    ct_we |=> cls_vld_r[$past(ct_waddr)])
    else $error("class entry written without valid bit");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status <= ST_STACK_FULL))
    else $error("status code out of range");

endmodule

// ===== design/scsa_ram.sv =====
// Generic single write port RAM with registered read.
module scsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/scsa_rem_div.sv =====
// Bit-serial restoring remainder unit, one numerator bit per cycle.
module scsa_rem_div #(
  parameter int NW = 32,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_r, num_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     trial;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[NW-1]};
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = DW'(trial);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the size class slot allocator: directed table plus random traffic, checked by a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scsa_pkg::*;

  localparam int NCLS    = 64;
  localparam int BASE    = 8;
  localparam int DEPTH   = 256;
  localparam int N_RAND  = 1270;
  localparam int LIMIT   = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  size_class_slot_allocator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // allocator mirror
  logic [31:0] m_stack [NCLS][DEPTH];
  int unsigned m_count [NCLS];
  logic [63:0] m_next [NCLS];
  logic [63:0] m_end [NCLS];
  logic [63:0] m_arena;
  logic [63:0] m_abase, m_alimit, m_bbytes;

  rsp_t        pending_rsps [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          stim_done = 1'b0;
  logic [31:0] live_addrs [NCLS][$];

  function automatic rsp_t mk(logic [31:0] a, logic [5:0] c, logic [2:0] s);
    rsp_t r;
    r.slot_addr = a; r.size_class = c; r.status = s;
    return r;
  endfunction

  function automatic void alloc_reset();
    for (int c = 0; c < NCLS; c++) begin
      m_count[c] = 0; m_next[c] = 0; m_end[c] = 0;
    end
    m_arena = 0; m_abase = 0; m_alimit = 0; m_bbytes = 4096;
  endfunction

  function automatic rsp_t predict_alloc(req_t q);
    logic [63:0] mask, size, addr, cls, slot, start, lim, e, body, first, rem;
    mask = 64'hFFFF_FFFF;
    size = q.req_size;
    addr = q.free_addr;
    if (size == 0 || (q.req_type == REQ_FREE && addr == 0)) return mk(0, 0, ST_IGNORED);
    if (size > NCLS * BASE) return mk(0, 0, ST_OVERSIZE);
    cls = (size - 1) / BASE;
    slot = (cls + 1) * BASE;
    if (q.req_type == REQ_FREE) begin
      if (m_count[cls] >= DEPTH) return mk(0, cls, ST_STACK_FULL);
      m_stack[cls][m_count[cls]] = addr;
      m_count[cls]++;
      return mk(addr, cls, ST_FROM_STACK);
    end
    if (m_count[cls] > 0) begin
      m_count[cls]--;
      return mk(m_stack[cls][m_count[cls]], cls, ST_FROM_STACK);
    end
    if (m_next[cls] == 0 || m_next[cls] > m_end[cls] || m_end[cls] - m_next[cls] < slot) begin
      start = (m_arena == 0 ? m_abase : m_arena) & mask;
      lim = m_alimit & mask;
      if (m_bbytes > mask - start || start + m_bbytes > lim || m_bbytes < HDR_BYTES ||
          HDR_BYTES > mask - start) return mk(0, cls, ST_EXHAUSTED);
      e = start + m_bbytes;
      body = start + HDR_BYTES;
      rem = body % slot;
      first = body;
      if (rem != 0) begin
        if (slot - rem > e - body) return mk(0, cls, ST_EXHAUSTED);
        first = body + (slot - rem);
      end
      if (first > e || e - first < slot) return mk(0, cls, ST_EXHAUSTED);
      m_arena = e; m_next[cls] = first; m_end[cls] = e;
    end
    first = m_next[cls];
    m_next[cls] = first + slot;
    return mk(first, cls, ST_CARVED);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ARENA_BASE:  m_abase = val;
      REG_ARENA_LIMIT: m_alimit = val;
      default:         m_bbytes = val[20:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send(req_t q, bit has_exp, rsp_t want);
    rsp_t p;
    p = predict_alloc(q);
    if (has_exp && p !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: row %h pred %h", want, p);
    end
    pending_rsps.push_back(p);
    if (q.req_type == REQ_ALLOC && (p.status == ST_CARVED || p.status == ST_FROM_STACK))
      live_addrs[p.size_class].push_back(p.slot_addr);
    in_word <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 9) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end else if ($urandom_range(0, 49) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 40)) @(negedge clk);
    end
  endtask

  function automatic req_t mkreq(logic t, logic [31:0] s, logic [31:0] a);
    req_t q;
    q.req_type = t; q.req_size = s; q.free_addr = a;
    return q;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word);
      end else begin
        if (out_word.slot_addr !== pending_rsps[0].slot_addr ||
            out_word.size_class !== pending_rsps[0].size_class ||
            out_word.status !== pending_rsps[0].status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr %h cls %0d st %0d, got addr %h cls %0d st %0d",
                     pending_rsps[0].slot_addr, pending_rsps[0].size_class,
                     pending_rsps[0].status, out_word.slot_addr, out_word.size_class,
                     out_word.status);
        end
        void'(pending_rsps.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (stim_done || $urandom_range(0, 9) < 6) out_ready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  typedef struct {
    req_t q;
    bit   has_exp;
    rsp_t want;
  } row_t;

  initial begin
    row_t rows [$];
    req_t q;
    int   cls;
    int   wait_cyc;
    alloc_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // after reset the arena is empty, so allocation reports exhaustion
    rows.push_back('{mkreq(REQ_ALLOC, 8, 0), 1, mk(0, 0, ST_EXHAUSTED)});
    rows.push_back('{mkreq(REQ_ALLOC, 0, 0), 1, mk(0, 0, ST_IGNORED)});
    rows.push_back('{mkreq(REQ_FREE, 0, 32'h40), 1, mk(0, 0, ST_IGNORED)});
    rows.push_back('{mkreq(REQ_FREE, 16, 0), 1, mk(0, 0, ST_IGNORED)});
    rows.push_back('{mkreq(REQ_ALLOC, 513, 0), 1, mk(0, 0, ST_OVERSIZE)});
    rows.push_back('{mkreq(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, mk(0, 0, ST_OVERSIZE)});
    rows.push_back('{mkreq(REQ_FREE, 512, 32'hFFFF_FFFF), 1, mk(32'hFFFF_FFFF, 63, ST_FROM_STACK)});
    rows.push_back('{mkreq(REQ_ALLOC, 512, 0), 1, mk(32'hFFFF_FFFF, 63, ST_FROM_STACK)});
    foreach (rows[i]) send(rows[i].q, rows[i].has_exp, rows[i].want);
    drain();

    write_reg(REG_ARENA_BASE, 32'h1000);
    write_reg(REG_ARENA_LIMIT, 32'h10_0000);
    write_reg(REG_BLOCK_BYTES, 64);
    rows.delete();
    rows.push_back('{mkreq(REQ_ALLOC, 1, 0), 1, mk(32'h1008, 0, ST_CARVED)});
    rows.push_back('{mkreq(REQ_ALLOC, 8, 0), 0, '0});
    rows.push_back('{mkreq(REQ_ALLOC, 9, 0), 0, '0});
    rows.push_back('{mkreq(REQ_ALLOC, 40, 0), 0, '0});
    rows.push_back('{mkreq(REQ_ALLOC, 57, 0), 0, '0});
    rows.push_back('{mkreq(REQ_ALLOC, 512, 0), 0, '0});
    rows.push_back('{mkreq(REQ_FREE, 24, 32'h1234_5678), 0, '0});
    rows.push_back('{mkreq(REQ_ALLOC, 17, 0), 0, '0});
    foreach (rows[i]) send(rows[i].q, rows[i].has_exp, rows[i].want);
    // fill one class stack past its depth
    for (int i = 0; i <= DEPTH; i++)
      send(mkreq(REQ_FREE, 100, 32'h8000_0000 | i), 0, '0);
    drain();

    // arena near top of address space
    write_reg(REG_ARENA_BASE, 32'hFFFF_FF00);
    write_reg(REG_ARENA_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_BLOCK_BYTES, 21'h1F_FFFF);
    send(mkreq(REQ_ALLOC, 200, 0), 0, '0);
    drain();
    write_reg(REG_BLOCK_BYTES, 128);
    for (int i = 0; i < 4; i++) send(mkreq(REQ_ALLOC, 8 * (i + 1), 0), 0, '0);
    drain();

    for (int n = 0; n < N_RAND; n++) begin
      if (n % 300 == 0) begin
        drain();
        case ((n / 300) % 3)
          0: begin
            write_reg(REG_ARENA_BASE, $urandom_range(0, 32'h1000) & ~32'h7);
            write_reg(REG_BLOCK_BYTES, $urandom_range(64, 1024));
            write_reg(REG_ARENA_LIMIT, 32'h0100_0000);
          end
          1: begin
            write_reg(REG_BLOCK_BYTES, $urandom_range(0, 21'h1F_FFFF));
            write_reg(REG_ARENA_LIMIT, $urandom());
          end
          default: begin
            write_reg(REG_ARENA_BASE, $urandom());
            write_reg(REG_ARENA_LIMIT, 32'hFFFF_FFFF);
            write_reg(REG_BLOCK_BYTES, $urandom_range(64, 4096));
          end
        endcase
      end
      wait_cyc = $urandom_range(0, 99);
      cls = $urandom_range(0, 15);
      if (wait_cyc < 45) begin
        q = mkreq(REQ_ALLOC, cls * BASE + $urandom_range(1, BASE), $urandom());
      end else if (wait_cyc < 80 && live_addrs[cls].size() != 0) begin
        q = mkreq(REQ_FREE, cls * BASE + $urandom_range(1, BASE), live_addrs[cls].pop_front());
      end else if (wait_cyc < 90) begin
        q = mkreq($urandom_range(0, 1), $urandom_range(1, NCLS * BASE), $urandom());
      end else begin
        q = mkreq($urandom_range(0, 1), $urandom(), $urandom());
        if ($urandom_range(0, 3) == 0) q.req_size = 0;
        if ($urandom_range(0, 3) == 0) q.free_addr = 0;
      end
      send(q, 0, '0);
    end

    stim_done = 1'b1;
    in_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/scsa_pkg.sv
design/scsa_ram.sv
design/scsa_rem_div.sv
design/size_class_slot_allocator_unit.sv
tb/sv/tb_top.sv
